// ===== rtl/ccwc_pkg.sv =====
// ccwc_pkg: shared types, codes and sizes of the complex coil weight combiner
// no dependencies
package ccwc_pkg;

  localparam int MAX_PIXELS_DEF = 256;
  localparam int MAX_COILS_DEF  = 32;
  localparam int MAX_SETS_DEF   = 4;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_COMMIT = 2'd2;

  localparam logic [1:0] REG_PIXELS = 2'd0;
  localparam logic [1:0] REG_COILS  = 2'd1;
  localparam logic [1:0] REG_SETS   = 2'd2;
  localparam logic [1:0] REG_GAIN   = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch_in;
    logic setup;
    logic w_write;
    logic commit;
    logic rd;
    logic mul;
    logic acc;
    logic fin_r;
    logic fin_i;
    logic out_load;
    logic out_err;
    logic next;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       weights_ok;
    logic       last_coil;
    logic       last_set;
    logic       out_free;
  } stat_t;

  // (v + 2^21) >>> 22, saturated to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [55:0] v);
    logic signed [56:0] t;
    logic signed [34:0] q;
    t = {v[55], v} + 57'sd2097152;
    q = t[56:22];
    if (q > 35'sd2147483647) begin
      round_sat = 32'sh7fffffff;
    end else if (q < -35'sd2147483648) begin
      round_sat = 32'sh80000000;
    end else begin
      round_sat = q[31:0];
    end
  endfunction

endpackage

// ===== rtl/complex_coil_weight_combiner_top.sv =====
// Complex coil weight combiner. An accepted item is processed alone: a weight write is
// decoded, then written; a commit is decoded; a sample is decoded, then per set does a
// weight and accumulator read, complex multiply, accumulate and advance, and at the last
// coil also the gain multiply, rounding and output load, which waits out an output stall.
// The shared complex multiplier and the single read port of each memory set that order.
// A result waits in the output register while the next item is taken. There is no
// clearing pass; weight and accumulator memories are undefined until written.
// depends on ccwc_pkg, ccwc_ctrl, ccwc_datapath, ccwc_ram
module complex_coil_weight_combiner_top #(
  parameter int MAX_PIXELS = ccwc_pkg::MAX_PIXELS_DEF,
  parameter int MAX_COILS  = ccwc_pkg::MAX_COILS_DEF,
  parameter int MAX_SETS   = ccwc_pkg::MAX_SETS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [14:0]        weight_index,
  input  logic signed [15:0] value_real,
  input  logic signed [15:0] value_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         set_index,
  output logic [7:0]         pixel_index,
  output logic signed [31:0] out_real,
  output logic signed [31:0] out_imag,
  output logic               status,
  output logic               last
);

  ccwc_pkg::cmd_t  cmd;
  ccwc_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  ccwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ccwc_datapath #(
    .MAX_PIXELS (MAX_PIXELS),
    .MAX_COILS  (MAX_COILS),
    .MAX_SETS   (MAX_SETS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .weight_index (weight_index),
    .value_real   (value_real),
    .value_imag   (value_imag),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .set_index    (set_index),
    .pixel_index  (pixel_index),
    .out_real     (out_real),
    .out_imag     (out_imag),
    .status       (status),
    .last         (last)
  );

endmodule

// ===== rtl/ccwc_ram.sv =====
// ccwc_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module ccwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ccwc_ctrl.sv =====
// ccwc_ctrl: sequencer of the combiner, one item at a time, one set per pass
// depends on ccwc_pkg
module ccwc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ccwc_pkg::stat_t st,
  output ccwc_pkg::cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SETUP = 11'b00000000010,
    S_WCHK  = 11'b00000000100,
    S_ERR   = 11'b00000001000,
    S_RD    = 11'b00000010000,
    S_MUL   = 11'b00000100000,
    S_ACC   = 11'b00001000000,
    S_FINR  = 11'b00010000000,
    S_FINI  = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_NEXT  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        case (st.op)
          ccwc_pkg::OP_WRITE:  state_next = S_WCHK;
          ccwc_pkg::OP_COMMIT: begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
          ccwc_pkg::OP_SAMPLE: state_next = st.weights_ok ? S_RD : S_ERR;
          default:             state_next = S_IDLE;
        endcase
      end
      S_WCHK: begin
        cmd.w_write = 1'b1;
        state_next = S_IDLE;
      end
      S_ERR: begin
        if (st.out_free) begin
          cmd.out_err = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        state_next = st.last_coil ? S_FINR : S_NEXT;
      end
      S_FINR: begin
        cmd.fin_r = 1'b1;
        state_next = S_FINI;
      end
      S_FINI: begin
        cmd.fin_i = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.next = 1'b1;
        state_next = st.last_set ? S_IDLE : S_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !st.out_free) |=> (state == S_OUT))
    else $error("result dropped while output register busy");
  a_accept_setup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_SETUP))
    else $error("accepted item not decoded");
`endif

endmodule

// ===== rtl/ccwc_datapath.sv =====
// ccwc_datapath: config registers, counters, weight and accumulator memories,
// complex multiply-accumulate, gain scaling and the output register; uses ccwc_pkg, ccwc_ram
module ccwc_datapath #(
  parameter int MAX_PIXELS = ccwc_pkg::MAX_PIXELS_DEF,
  parameter int MAX_COILS  = ccwc_pkg::MAX_COILS_DEF,
  parameter int MAX_SETS   = ccwc_pkg::MAX_SETS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [1:0]          opcode,
  input  logic [14:0]         weight_index,
  input  logic signed [15:0]  value_real,
  input  logic signed [15:0]  value_imag,
  input  ccwc_pkg::cmd_t      cmd,
  output ccwc_pkg::stat_t     st,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          set_index,
  output logic [7:0]          pixel_index,
  output logic signed [31:0]  out_real,
  output logic signed [31:0]  out_imag,
  output logic                status,
  output logic                last
);

  localparam int NPW = $clog2(MAX_PIXELS + 1);
  localparam int NCW = $clog2(MAX_COILS + 1);
  localparam int NSW = $clog2(MAX_SETS + 1);
  localparam int PW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW  = (MAX_COILS > 1) ? $clog2(MAX_COILS) : 1;
  localparam int SW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WDEPTH = MAX_PIXELS * MAX_COILS * MAX_SETS;
  localparam int ADEPTH = MAX_PIXELS * MAX_SETS;
  localparam int WAW = $clog2(WDEPTH > 1 ? WDEPTH : 2);
  localparam int AAW = $clog2(ADEPTH > 1 ? ADEPTH : 2);
  localparam int STW = NPW + NCW;

  logic [8:0]         pixel_count;
  logic [5:0]         coil_count;
  logic [2:0]         set_count;
  logic signed [15:0] gain;

  logic [1:0]         op;
  logic [14:0]        idx;
  logic signed [15:0] xr, xi;
  logic               weights_valid;

  logic [PW-1:0]      pix;
  logic [CW-1:0]      coil;
  logic [SW-1:0]      set_sel;
  logic               last_coil;
  logic [STW-1:0]     stride;
  logic [WAW-1:0]     waddr;
  logic [AAW-1:0]     aaddr;

  logic [NPW-1:0]     np;
  logic [NCW-1:0]     nc;
  logic [NSW-1:0]     ns;
  logic [PW-1:0]      pix_n;
  logic [CW-1:0]      coil_n;
  logic [STW-1:0]     base;
  logic [STW+NSW-1:0] limit;
  logic               idx_ok;

  logic [31:0]        w_rd;
  logic [79:0]        acc_rd;
  logic signed [32:0] prod_r, prod_i;
  logic signed [39:0] sum_r, sum_i;
  logic signed [39:0] acc_r_old, acc_i_old, sum_r_next, sum_i_next;
  logic signed [55:0] gprod_r, gprod_i;
  logic signed [31:0] res_r;

  // size clamps: zero counts as one, large values saturate to the maximum
  always_comb begin
    if (pixel_count == 9'd0) begin
      np = NPW'(1);
    end else if (32'(pixel_count) > 32'(MAX_PIXELS)) begin
      np = NPW'(MAX_PIXELS);
    end else begin
      np = NPW'(pixel_count);
    end
    if (coil_count == 6'd0) begin
      nc = NCW'(1);
    end else if (32'(coil_count) > 32'(MAX_COILS)) begin
      nc = NCW'(MAX_COILS);
    end else begin
      nc = NCW'(coil_count);
    end
    if (set_count == 3'd0) begin
      ns = NSW'(1);
    end else if (32'(set_count) > 32'(MAX_SETS)) begin
      ns = NSW'(MAX_SETS);
    end else begin
      ns = NSW'(set_count);
    end
  end

  // counters beyond a shrunk size restart at zero
  assign pix_n  = (32'(pix) >= 32'(np)) ? '0 : pix;
  assign coil_n = (32'(coil) >= 32'(nc)) ? '0 : coil;
  assign base   = STW'(STW'(coil_n) * STW'(np)) + STW'(pix_n);
  assign limit  = (STW + NSW)'(stride) * (STW + NSW)'(ns);
  assign idx_ok = 32'(idx) < 32'(limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= 9'd256;
      coil_count  <= 6'd1;
      set_count   <= 3'd1;
      gain        <= 16'sd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ccwc_pkg::REG_PIXELS: pixel_count <= cfg_data[8:0];
        ccwc_pkg::REG_COILS:  coil_count  <= cfg_data[5:0];
        ccwc_pkg::REG_SETS:   set_count   <= cfg_data[2:0];
        ccwc_pkg::REG_GAIN:   gain        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weights_valid <= 1'b0;
      pix           <= '0;
      coil          <= '0;
    end else begin
      if (cmd.commit) begin
        weights_valid <= 1'b1;
      end
      if (cmd.setup && op == ccwc_pkg::OP_SAMPLE) begin
        pix  <= pix_n;
        coil <= coil_n;
      end else if (cmd.next && st.last_set) begin
        if (32'(pix) + 32'd1 >= 32'(np)) begin
          pix  <= '0;
          coil <= last_coil ? '0 : coil + CW'(1);
        end else begin
          pix <= pix + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op  <= opcode;
      idx <= weight_index;
      xr  <= value_real;
      xi  <= value_imag;
    end
    if (cmd.setup) begin
      stride    <= STW'(np) * STW'(nc);
      waddr     <= WAW'(base);
      aaddr     <= AAW'(pix_n);
      set_sel   <= '0;
      last_coil <= (32'(coil_n) + 32'd1 >= 32'(nc));
    end
    if (cmd.next) begin
      set_sel <= set_sel + SW'(1);
      waddr   <= waddr + WAW'(stride);
      aaddr   <= aaddr + AAW'(MAX_PIXELS);
    end
    if (cmd.mul) begin
      prod_r <= 33'($signed(w_rd[15:0]) * xr) - 33'($signed(w_rd[31:16]) * xi);
      prod_i <= 33'($signed(w_rd[15:0]) * xi) + 33'($signed(w_rd[31:16]) * xr);
    end
    if (cmd.acc) begin
      sum_r <= sum_r_next;
      sum_i <= sum_i_next;
    end
    if (cmd.fin_r) begin
      gprod_r <= 56'(sum_r) * 56'(gain);
    end
    if (cmd.fin_i) begin
      gprod_i <= 56'(sum_i) * 56'(gain);
      res_r   <= ccwc_pkg::round_sat(gprod_r);
    end
  end

  // coil zero restarts the per pixel sum
  assign acc_r_old  = (coil == '0) ? 40'sd0 : $signed(acc_rd[39:0]);
  assign acc_i_old  = (coil == '0) ? 40'sd0 : $signed(acc_rd[79:40]);
  assign sum_r_next = acc_r_old + 40'(prod_r);
  assign sum_i_next = acc_i_old + 40'(prod_i);

  ccwc_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_wram (
    .clk   (clk),
    .we    (cmd.w_write && idx_ok),
    .waddr (WAW'(idx)),
    .wdata ({xi, xr}),
    .re    (cmd.rd),
    .raddr (waddr),
    .rdata (w_rd)
  );

  ccwc_ram #(.WIDTH(80), .DEPTH(ADEPTH)) u_aram (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (aaddr),
    .wdata ({sum_i_next, sum_r_next}),
    .re    (cmd.rd),
    .raddr (aaddr),
    .rdata (acc_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load || cmd.out_err) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      set_index   <= 2'(set_sel);
      pixel_index <= 8'(pix);
      out_real    <= res_r;
      out_imag    <= ccwc_pkg::round_sat(gprod_i);
      status      <= 1'b0;
      last        <= st.last_set;
    end else if (cmd.out_err) begin
      set_index   <= 2'd0;
      pixel_index <= 8'(pix);
      out_real    <= '0;
      out_imag    <= '0;
      status      <= 1'b1;
      last        <= 1'b1;
    end
  end

  assign st.op         = op;
  assign st.weights_ok = weights_valid;
  assign st.last_coil  = last_coil;
  assign st.last_set   = (32'(set_sel) + 32'd1 >= 32'(ns));
  assign st.out_free   = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load || cmd.out_err) |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");
  a_set_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd || cmd.acc) |-> (32'(set_sel) < 32'(ns)))
    else $error("set counter beyond set count");
  a_mac_order: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> $past(cmd.mul))
    else $error("accumulate without fresh product");
`endif

endmodule
